@@ rtl/mmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants for the dual HI/LO multiply/divide unit.
// ----------------------------------------------------------------------------
package mmd_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned REG_W    = 64;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned DEST_W   = 5;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned IN_DW    = 72;   // a, b, dest_index, zero fill
	localparam int unsigned IN_UW    = 4;    // mode, pipe_select
	localparam int unsigned OUT_DW   = 136;  // lo, hi, dest_out, zero fill
	localparam int unsigned OUT_UW   = 1;    // dest_write

	localparam logic [CNT_W-1:0] DIV_LAST = {CNT_W{1'b1}};

	localparam logic [MODE_W-1:0] MODE_SMULT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UMULT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SDIV  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UDIV  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} mmd_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the incoming request
		logic mul_en;    // register the product
		logic div_step;  // one restoring divide step
		logic commit;    // update the pair and the output register
	} mmd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_is_mul;
		logic in_is_div;
	} mmd_stat_t;

	function automatic logic [REG_W-1:0] sext32(input logic [WORD_W-1:0] v);
		sext32 = {{(REG_W-WORD_W){v[WORD_W-1]}}, v};
	endfunction

endpackage
`default_nettype wire

@@ rtl/mmd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_ctrl
// Sequencer: accepts one request, runs mul/div/read, hands off result.
// ----------------------------------------------------------------------------
module mmd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire mmd_pkg::mmd_stat_t stat,
	output mmd_pkg::mmd_cmd_t       cmd
);

	mmd_pkg::mmd_state_t             state_q, state_d;
	logic [mmd_pkg::CNT_W-1:0]       cnt_q;
	logic                            out_valid_q;
	logic                            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		case (state_q)
			mmd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.in_is_mul)
						state_d = mmd_pkg::ST_MUL;
					else if (stat.in_is_div)
						state_d = mmd_pkg::ST_DIV;
					else
						state_d = mmd_pkg::ST_FIN;
				end
			end
			mmd_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = mmd_pkg::ST_FIN;
			end
			mmd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == mmd_pkg::DIV_LAST)
					state_d = mmd_pkg::ST_FIN;
			end
			mmd_pkg::ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = mmd_pkg::ST_IDLE;
				end
			end
			default: state_d = mmd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/mmd_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_dpath
// Operand registers, multiplier, radix-2 divider, HI/LO pairs, output reg.
// ----------------------------------------------------------------------------
module mmd_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [mmd_pkg::IN_DW-1:0]     in_data,
	input  wire logic [mmd_pkg::IN_UW-1:0]     in_user,
	input  wire mmd_pkg::mmd_cmd_t             cmd,
	output mmd_pkg::mmd_stat_t                 stat,
	output logic [mmd_pkg::OUT_DW-1:0]         out_data,
	output logic [mmd_pkg::OUT_UW-1:0]         out_user
);

	localparam int unsigned W = mmd_pkg::WORD_W;

	// incoming request fields
	logic [mmd_pkg::MODE_W-1:0] in_mode;
	logic                       in_sel;
	logic [W-1:0]               in_a, in_b;
	logic [mmd_pkg::DEST_W-1:0] in_dest;
	logic                       in_sdiv, a_neg, b_neg;
	logic [W-1:0]               a_mag, b_mag;

	assign in_mode = in_user[mmd_pkg::MODE_W-1:0];
	assign in_sel  = in_user[mmd_pkg::MODE_W];
	assign in_a    = in_data[W-1:0];
	assign in_b    = in_data[2*W-1:W];
	assign in_dest = in_data[2*W+mmd_pkg::DEST_W-1:2*W];

	assign stat.in_is_mul = (in_mode == mmd_pkg::MODE_SMULT) || (in_mode == mmd_pkg::MODE_UMULT);
	assign stat.in_is_div = (in_mode == mmd_pkg::MODE_SDIV) || (in_mode == mmd_pkg::MODE_UDIV);

	assign in_sdiv = (in_mode == mmd_pkg::MODE_SDIV);
	assign a_neg   = in_sdiv && in_a[W-1];
	assign b_neg   = in_sdiv && in_b[W-1];
	assign a_mag   = a_neg ? -in_a : in_a;
	assign b_mag   = b_neg ? -in_b : in_b;

	// captured request
	logic [mmd_pkg::MODE_W-1:0] mode_q;
	logic                       sel_q;
	logic [W-1:0]               a_q, b_q;
	logic [mmd_pkg::DEST_W-1:0] dest_q;
	logic                       qneg_q, rneg_q;

	// divider state: quo_q shifts dividend bits out and quotient bits in
	logic [W-1:0]               quo_q, rem_q, dvs_q;
	logic [W:0]                 rem_sh;
	logic [W+1:0]               diff;
	logic                       ge;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = !diff[W+1];

	// multiplier, one signed 33x33 product covers both signednesses
	logic                       msgn;
	logic signed [2*W+1:0]      prod_full;
	logic [2*W-1:0]             prod_q;

	assign msgn      = (mode_q == mmd_pkg::MODE_SMULT);
	assign prod_full = $signed({msgn && a_q[W-1], a_q}) * $signed({msgn && b_q[W-1], b_q});

	// HI/LO pairs
	logic [mmd_pkg::REG_W-1:0]  hi_q [2];
	logic [mmd_pkg::REG_W-1:0]  lo_q [2];

	// result of the current request
	logic [W-1:0]               quo_fix, rem_fix;
	logic [mmd_pkg::REG_W-1:0]  new_lo, new_hi;
	logic                       wr_pair, dwr;

	assign quo_fix = qneg_q ? -quo_q : quo_q;
	assign rem_fix = rneg_q ? -rem_q : rem_q;

	always_comb begin
		new_lo  = lo_q[sel_q];
		new_hi  = hi_q[sel_q];
		wr_pair = 1'b0;
		dwr     = 1'b0;
		case (mode_q)
			mmd_pkg::MODE_SMULT, mmd_pkg::MODE_UMULT: begin
				new_lo  = mmd_pkg::sext32(prod_q[W-1:0]);
				new_hi  = mmd_pkg::sext32(prod_q[2*W-1:W]);
				wr_pair = 1'b1;
				dwr     = (dest_q != '0);
			end
			mmd_pkg::MODE_SDIV: begin
				wr_pair = 1'b1;
				if (b_q == '0) begin
					// divide by zero: quotient +1 if a < 0, else -1; dividend as remainder
					new_lo = a_q[W-1] ? mmd_pkg::REG_W'(1) : {mmd_pkg::REG_W{1'b1}};
					new_hi = mmd_pkg::sext32(a_q);
				end else begin
					new_lo = mmd_pkg::sext32(quo_fix);
					new_hi = mmd_pkg::sext32(rem_fix);
				end
			end
			mmd_pkg::MODE_UDIV: begin
				// zero divisor falls out of the restoring loop as all ones / a
				wr_pair = 1'b1;
				new_lo  = mmd_pkg::sext32(quo_q);
				new_hi  = mmd_pkg::sext32(rem_q);
			end
			default: begin
				wr_pair = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			sel_q  <= in_sel;
			a_q    <= in_a;
			b_q    <= in_b;
			dest_q <= in_dest;
			qneg_q <= a_neg ^ b_neg;
			rneg_q <= a_neg;
			quo_q  <= a_mag;
			rem_q  <= '0;
			dvs_q  <= b_mag;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
		if (cmd.mul_en)
			prod_q <= prod_full[2*W-1:0];
		if (cmd.commit) begin
			out_data <= {{(mmd_pkg::OUT_DW-2*mmd_pkg::REG_W-mmd_pkg::DEST_W){1'b0}},
				(dwr ? dest_q : {mmd_pkg::DEST_W{1'b0}}), new_hi, new_lo};
			out_user <= dwr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q[0] <= '0;
			hi_q[1] <= '0;
			lo_q[0] <= '0;
			lo_q[1] <= '0;
		end else if (cmd.commit && wr_pair) begin
			hi_q[sel_q] <= new_hi;
			lo_q[sel_q] <= new_lo;
		end
	end

endmodule
`default_nettype wire

@@ rtl/mips_mult_div_unit_dual_hilo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mips_mult_div_unit_dual_hilo
// Multiply/divide unit with two HI/LO pairs, one per pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one request: mode and pair select in s_tuser,
//   operands and LO destination in s_tdata. One request is worked at a time;
//   s_tready is high only while the unit is idle.
//   Output stream returns the selected pair after the request, plus the
//   destination write flag (m_tuser) for multiplies with a nonzero target.
//   Work between request accept and m_tvalid:
//     read            straight to the commit state
//     multiply        one registered 33x33 multiply
//     divide          32 restoring steps of one shared subtractor
//   A divide runs to its end before the unit takes the next request; the
//   radix-2 divide loop holds the sequencer busy until then.
//   A finished result sits in the output register; the unit takes the next
//   request while it waits. If m_tready stays low, the following result is
//   held back in the sequencer until the output register drains.
//   Reset clears both HI/LO pairs to zero and drops m_tvalid.
// ----------------------------------------------------------------------------
module mips_mult_div_unit_dual_hilo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request channel
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [71:0]  s_tdata,   // operand_a[31:0], operand_b[63:32],
	                                     // dest_index[68:64], zero[71:69]
	input  wire logic [3:0]   s_tuser,   // mode[2:0], pipe_select[3]
	// result channel
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [135:0]      m_tdata,   // lo_value[63:0], hi_value[127:64],
	                                     // dest_out[132:128], zero[135:133]
	output logic [0:0]        m_tuser    // dest_write[0]
);

	mmd_pkg::mmd_cmd_t  cmd;
	mmd_pkg::mmd_stat_t stat;

	// sequencer: handshakes, step counter, output valid
	mmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic, pair state and result payload
	mmd_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);

endmodule
`default_nettype wire

@@ rtl/mmd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks for the multiply/divide unit, bound to the top level.
// ----------------------------------------------------------------------------
module mmd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [135:0] m_tdata,
	input wire logic [0:0]   m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time: ready drops after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// destination flag and index agree
	a_dest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] ? (m_tdata[132:128] != 5'd0) : (m_tdata[132:128] == 5'd0)))
		else $error("dest_out inconsistent with dest_write");

	// both halves are sign-extended 32-bit values
	a_sext: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[63:32] == {32{m_tdata[31]}}) &&
			(m_tdata[127:96] == {32{m_tdata[95]}}))
		else $error("HI/LO not sign-extended");

endmodule

bind mips_mult_div_unit_dual_hilo mmd_checker u_mmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
